// ===== rtl/mbcf_pkg.sv =====
// ============================================================================
// Matroska cluster framer package
// Shared types, constants and helper functions of the cluster framer.
// ============================================================================
package mbcf_pkg;

    localparam int TIME_BITS_DEF  = 48;
    localparam int LEN_BITS_DEF   = 24;
    localparam int TIME_MAX_BITS  = 64;
    localparam int BLEN_BITS      = 28;
    localparam int BODY_BITS      = 48;
    localparam int CHUNK_BITS     = 31;
    localparam int CFG_DATA_BITS  = 31;
    localparam int CFG_IDX_BITS   = 2;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [BODY_BITS-1:0]  BODY_MAX       = '1;
    localparam logic [CHUNK_BITS-1:0] SEG_DEFAULT_MS = 31'd2000;
    localparam logic [CHUNK_BITS-1:0] CHUNK_RESET    = 31'd1;
    localparam logic [31:0]           CLUSTER_ID     = 32'h1F43_B675;
    localparam logic [7:0]            BLOCK_ID       = 8'hA3;
    localparam logic [7:0]            TIMECODE_ID    = 8'hE7;
    localparam logic [7:0]            TRACK_VIDEO    = 8'h81;
    localparam logic [7:0]            TRACK_AUDIO    = 8'h82;
    localparam logic [7:0]            FLAG_KEY       = 8'h80;
    localparam logic [7:0]            FLAG_NONE      = 8'h00;
    localparam logic [7:0]            SIZE_MARKER    = 8'h80;
    localparam logic [15:0]           REL_MAX        = 16'h7FFF;
    localparam logic [15:0]           REL_MIN        = 16'h8000;

    localparam logic CMD_FRAME = 1'b0;
    localparam logic CMD_CLOSE = 1'b1;

    typedef enum logic [1:0] {
        CFG_SEGMENTED   = 2'd0,
        CFG_SEG_MS      = 2'd1,
        CFG_AUDIO_EN    = 2'd2,
        CFG_FIRST_CHUNK = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_CLUSTER = 2'd0,
        KIND_BLOCK   = 2'd1,
        KIND_REJECT  = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CID,
        S_CSIZE,
        S_TCID,
        S_TCLEN,
        S_TC,
        S_BID,
        S_BSIZE,
        S_TRACK,
        S_RELH,
        S_RELL,
        S_FLAGS,
        S_REJ
    } t_bstate;

    typedef struct packed {
        logic                     flush;
        logic                     blk;
        logic                     rej;
        logic                     audio;
        logic                     key;
        logic [CHUNK_BITS-1:0]    chunk;
        logic [TIME_MAX_BITS-1:0] tc;
        logic [3:0]               tn;
        logic [BODY_BITS-1:0]     body;
        logic [15:0]              rel;
        logic [BLEN_BITS-1:0]     blen;
    } t_job;

    function automatic logic [3:0] vint_len(input logic [63:0] v);
        logic [3:0] n;
        n = 4'd1;
        for (int k = 1; k < 8; k++) begin
            if (v >= ((64'd1 << (7 * k)) - 64'd1)) begin
                n = 4'(k + 1);
            end
        end
        return n;
    endfunction

    function automatic logic [3:0] tc_bytes(input logic [63:0] tc);
        logic [3:0] n;
        n = 4'd1;
        for (int k = 1; k < 8; k++) begin
            if ((tc >> (8 * k)) != 64'd0) begin
                n = 4'(k + 1);
            end
        end
        return n;
    endfunction

endpackage

// ===== rtl/mbcf_item_if.sv =====
// ============================================================================
// Frame descriptor channel
// Valid/ready channel that carries one frame descriptor or close command.
// ============================================================================
interface mbcf_item_if #(
    parameter int TIME_BITS = mbcf_pkg::TIME_BITS_DEF,
    parameter int LEN_BITS  = mbcf_pkg::LEN_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic                        is_audio;
    logic                        keyframe;
    logic signed [TIME_BITS-1:0] timestamp_ms;
    logic [LEN_BITS-1:0]         payload_len;

    modport source (
        output valid, cmd, is_audio, keyframe, timestamp_ms, payload_len,
        input  ready
    );
    modport sink (
        input  valid, cmd, is_audio, keyframe, timestamp_ms, payload_len,
        output ready
    );
endinterface

// ===== rtl/mbcf_result_if.sv =====
// ============================================================================
// Header byte channel
// Valid/ready channel that carries one header byte or reject marker.
// ============================================================================
interface mbcf_result_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        kind;
    logic [7:0]                        data_byte;
    logic [mbcf_pkg::CHUNK_BITS-1:0]   chunk_number;
    logic                              last;

    modport source (
        output valid, kind, data_byte, chunk_number, last,
        input  ready
    );
    modport sink (
        input  valid, kind, data_byte, chunk_number, last,
        output ready
    );
endinterface

// ===== rtl/matroska_block_cluster_framer.sv =====
// ============================================================================
// Matroska block and cluster header framer
// Turns frame descriptors and close commands into SimpleBlock and Cluster
// header bytes, one byte per output transaction.
// ============================================================================
// The front takes one transaction per cycle, updates the open cluster's base
// time, byte count and chunk number at once, and writes a decoded job into a
// four-entry queue; it stalls only when that queue is full. The back loads a
// job while idle and then sends it one header byte per output transaction,
// holding under back-pressure: a reject marker, a block header, or a cluster
// header that may be followed by a block header. The back's byte serializer
// sets the sustained rate, and the queue lets the front run ahead of it.
module matroska_block_cluster_framer #(
    parameter int TIME_BITS = mbcf_pkg::TIME_BITS_DEF,
    parameter int LEN_BITS  = mbcf_pkg::LEN_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [mbcf_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [mbcf_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    mbcf_item_if.sink                            i_item,
    mbcf_result_if.source                        o_result
);
    logic           w_q_full;
    logic           w_push;
    mbcf_pkg::t_job w_push_job;
    logic           w_q_valid;
    mbcf_pkg::t_job w_head_job;
    logic           w_pop;

    mbcf_front #(
        .TIME_BITS (TIME_BITS),
        .LEN_BITS  (LEN_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_item),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_job      (w_push_job)
    );

    mbcf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_job   (w_head_job),
        .i_pop   (w_pop)
    );

    mbcf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_job     (w_head_job),
        .o_pop     (w_pop),
        .o_result  (o_result)
    );
endmodule

// ===== rtl/mbcf_queue.sv =====
// ============================================================================
// Cluster framer job queue
// Small register FIFO of decoded jobs between the front and the back.
// ============================================================================
module mbcf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mbcf_pkg::t_job i_job,
    output logic           o_full,
    output logic           o_valid,
    output mbcf_pkg::t_job o_job,
    input  logic           i_pop
);
    localparam int DEPTH  = mbcf_pkg::QUEUE_DEPTH;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    mbcf_pkg::t_job   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end
endmodule

// ===== rtl/mbcf_front.sv =====
// ============================================================================
// Cluster framer front
// Accepts descriptors, keeps the cluster state and queues decoded jobs.
// ============================================================================
module mbcf_front #(
    parameter int TIME_BITS = mbcf_pkg::TIME_BITS_DEF,
    parameter int LEN_BITS  = mbcf_pkg::LEN_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [mbcf_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [mbcf_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    mbcf_item_if.sink                            i_item,
    input  logic                                 i_q_full,
    output logic                                 o_push,
    output mbcf_pkg::t_job                       o_job
);
    localparam int BB = mbcf_pkg::BODY_BITS;
    localparam int CB = mbcf_pkg::CHUNK_BITS;
    localparam int LB = mbcf_pkg::BLEN_BITS;

    logic                        r_seg_mode;
    logic [CB-1:0]               r_seg_ms;
    logic                        r_audio_en;
    logic [CB-1:0]               r_next_chunk;
    logic                        r_active;
    logic signed [TIME_BITS-1:0] r_start;
    logic [BB-1:0]               r_body;

    logic                 w_accept;
    logic                 w_close;
    logic                 w_key;
    logic                 w_reject;
    logic                 w_frame;
    logic [TIME_BITS:0]   w_d;
    logic                 w_nonneg;
    logic [CB-1:0]        w_seg;
    logic                 w_elapsed;
    logic                 w_boundary;
    logic                 w_flush;
    logic [15:0]          w_rel;
    logic [LB-1:0]        w_blen;
    logic [LB-1:0]        w_add;
    logic [BB-1:0]        w_body_base;
    logic [BB:0]          w_sum;
    logic [BB-1:0]        w_body_next;

    assign i_item.ready = !i_q_full;
    assign w_accept     = i_item.valid && !i_q_full;

    assign w_close  = (i_item.cmd == mbcf_pkg::CMD_CLOSE);
    assign w_key    = !i_item.is_audio && i_item.keyframe;
    assign w_reject = !w_close && ((i_item.payload_len == '0) ||
                                   (i_item.is_audio && !r_audio_en));
    assign w_frame  = !w_close && !w_reject;

    assign w_d      = {i_item.timestamp_ms[TIME_BITS-1], i_item.timestamp_ms}
                    - {r_start[TIME_BITS-1], r_start};
    assign w_nonneg = !w_d[TIME_BITS];
    assign w_seg    = (r_seg_ms == '0) ? mbcf_pkg::SEG_DEFAULT_MS : r_seg_ms;
    assign w_elapsed = w_nonneg && (w_d[TIME_BITS-1:0] >= TIME_BITS'(w_seg));

    assign w_boundary = w_frame && (!r_active ||
                                    (w_key && (!r_seg_mode || w_elapsed)));
    assign w_flush    = (w_close || w_boundary) && r_active && (r_body != '0);

    always_comb begin
        if (w_boundary) begin
            w_rel = '0;
        end else if (w_nonneg) begin
            w_rel = (|w_d[TIME_BITS-1:15]) ? mbcf_pkg::REL_MAX : w_d[15:0];
        end else begin
            w_rel = (&w_d[TIME_BITS:15]) ? w_d[15:0] : mbcf_pkg::REL_MIN;
        end
    end

    assign w_blen      = LB'(i_item.payload_len) + LB'(4);
    assign w_add       = w_blen + LB'(mbcf_pkg::vint_len(64'(w_blen))) + LB'(1);
    assign w_body_base = w_boundary ? '0 : r_body;
    assign w_sum       = {1'b0, w_body_base} + (BB + 1)'(w_add);
    assign w_body_next = w_sum[BB] ? mbcf_pkg::BODY_MAX : w_sum[BB-1:0];

    assign o_push = w_accept && (w_flush || w_frame || w_reject);

    always_comb begin
        o_job       = '0;
        o_job.flush = w_flush;
        o_job.blk   = w_frame;
        o_job.rej   = w_reject;
        o_job.audio = i_item.is_audio;
        o_job.key   = w_key;
        o_job.chunk = r_next_chunk;
        o_job.tc    = 64'(r_start);
        o_job.tn    = mbcf_pkg::tc_bytes(64'(r_start));
        o_job.body  = r_body;
        o_job.rel   = w_rel;
        o_job.blen  = w_blen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_mode   <= 1'b0;
            r_seg_ms     <= mbcf_pkg::SEG_DEFAULT_MS;
            r_audio_en   <= 1'b0;
            r_next_chunk <= mbcf_pkg::CHUNK_RESET;
            r_active     <= 1'b0;
            r_start      <= '0;
            r_body       <= '0;
        end else if (i_cfg_we) begin
            unique case (mbcf_pkg::t_cfg_idx'(i_cfg_idx))
                mbcf_pkg::CFG_SEGMENTED: begin
                    r_seg_mode <= i_cfg_data[0];
                end
                mbcf_pkg::CFG_SEG_MS: begin
                    r_seg_ms <= i_cfg_data;
                end
                mbcf_pkg::CFG_AUDIO_EN: begin
                    r_audio_en <= i_cfg_data[0];
                end
                mbcf_pkg::CFG_FIRST_CHUNK: begin
                    r_next_chunk <= i_cfg_data;
                end
                default: begin
                    r_seg_mode <= r_seg_mode;
                end
            endcase
        end else if (w_accept) begin
            if (w_flush && r_seg_mode) begin
                r_next_chunk <= r_next_chunk + CB'(1);
            end
            if (w_close) begin
                r_active <= 1'b0;
                r_body   <= '0;
            end else if (w_frame) begin
                if (w_boundary) begin
                    r_active <= 1'b1;
                    r_start  <= i_item.timestamp_ms;
                end
                r_body <= w_body_next;
            end
        end
    end
endmodule

// ===== rtl/mbcf_back.sv =====
// ============================================================================
// Cluster framer back
// Serializes queued jobs into header bytes through an output register.
// ============================================================================
module mbcf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  mbcf_pkg::t_job i_job,
    output logic           o_pop,
    mbcf_result_if.source  o_result
);
    localparam int CB = mbcf_pkg::CHUNK_BITS;

    mbcf_pkg::t_bstate r_state;
    mbcf_pkg::t_bstate n_state;
    logic [2:0]        r_idx;
    logic [2:0]        n_idx;
    mbcf_pkg::t_job    r_job;
    logic [63:0]       r_csz;
    logic [3:0]        r_cn;
    logic [3:0]        r_bn;

    logic              r_out_valid;
    logic [1:0]        r_kind;
    logic [7:0]        r_byte;
    logic [CB-1:0]     r_chunk;
    logic              r_last;

    logic              w_adv;
    logic              w_load;
    logic [63:0]       w_csz;
    logic [63:0]       w_blen64;
    logic [1:0]        w_kind;
    logic [7:0]        w_byte;
    logic              w_last;

    assign w_adv    = (r_state != mbcf_pkg::S_IDLE) && (!r_out_valid || o_result.ready);
    assign w_load   = (r_state == mbcf_pkg::S_IDLE) && i_q_valid;
    assign o_pop    = w_load;
    assign w_csz    = 64'(i_job.body) + 64'(i_job.tn) + 64'd2;
    assign w_blen64 = 64'(r_job.blen);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            mbcf_pkg::S_IDLE: begin
                n_idx = 3'd3;
                if (i_q_valid) begin
                    if (i_job.flush) begin
                        n_state = mbcf_pkg::S_CID;
                    end else if (i_job.blk) begin
                        n_state = mbcf_pkg::S_BID;
                    end else begin
                        n_state = mbcf_pkg::S_REJ;
                    end
                end
            end
            mbcf_pkg::S_CID: begin
                if (w_adv) begin
                    n_idx = r_idx - 3'd1;
                    if (r_idx == 3'd0) begin
                        n_state = mbcf_pkg::S_CSIZE;
                        n_idx   = 3'(r_cn - 4'd1);
                    end
                end
            end
            mbcf_pkg::S_CSIZE: begin
                if (w_adv) begin
                    n_idx = r_idx - 3'd1;
                    if (r_idx == 3'd0) begin
                        n_state = mbcf_pkg::S_TCID;
                    end
                end
            end
            mbcf_pkg::S_TCID: begin
                if (w_adv) begin
                    n_state = mbcf_pkg::S_TCLEN;
                end
            end
            mbcf_pkg::S_TCLEN: begin
                if (w_adv) begin
                    n_state = mbcf_pkg::S_TC;
                    n_idx   = 3'(r_job.tn - 4'd1);
                end
            end
            mbcf_pkg::S_TC: begin
                if (w_adv) begin
                    n_idx = r_idx - 3'd1;
                    if (r_idx == 3'd0) begin
                        n_state = r_job.blk ? mbcf_pkg::S_BID : mbcf_pkg::S_IDLE;
                    end
                end
            end
            mbcf_pkg::S_BID: begin
                if (w_adv) begin
                    n_state = mbcf_pkg::S_BSIZE;
                    n_idx   = 3'(r_bn - 4'd1);
                end
            end
            mbcf_pkg::S_BSIZE: begin
                if (w_adv) begin
                    n_idx = r_idx - 3'd1;
                    if (r_idx == 3'd0) begin
                        n_state = mbcf_pkg::S_TRACK;
                    end
                end
            end
            mbcf_pkg::S_TRACK: begin
                if (w_adv) begin
                    n_state = mbcf_pkg::S_RELH;
                end
            end
            mbcf_pkg::S_RELH: begin
                if (w_adv) begin
                    n_state = mbcf_pkg::S_RELL;
                end
            end
            mbcf_pkg::S_RELL: begin
                if (w_adv) begin
                    n_state = mbcf_pkg::S_FLAGS;
                end
            end
            mbcf_pkg::S_FLAGS, mbcf_pkg::S_REJ: begin
                if (w_adv) begin
                    n_state = mbcf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mbcf_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        w_kind = mbcf_pkg::KIND_BLOCK;
        w_byte = '0;
        w_last = 1'b0;
        unique case (r_state)
            mbcf_pkg::S_CID: begin
                w_kind = mbcf_pkg::KIND_CLUSTER;
                w_byte = mbcf_pkg::CLUSTER_ID[8 * r_idx[1:0] +: 8];
            end
            mbcf_pkg::S_CSIZE: begin
                w_kind = mbcf_pkg::KIND_CLUSTER;
                w_byte = r_csz[8 * r_idx +: 8];
                if (r_idx == 3'(r_cn - 4'd1)) begin
                    w_byte = w_byte | (mbcf_pkg::SIZE_MARKER >> r_idx);
                end
            end
            mbcf_pkg::S_TCID: begin
                w_kind = mbcf_pkg::KIND_CLUSTER;
                w_byte = mbcf_pkg::TIMECODE_ID;
            end
            mbcf_pkg::S_TCLEN: begin
                w_kind = mbcf_pkg::KIND_CLUSTER;
                w_byte = mbcf_pkg::SIZE_MARKER | 8'(r_job.tn);
            end
            mbcf_pkg::S_TC: begin
                w_kind = mbcf_pkg::KIND_CLUSTER;
                w_byte = r_job.tc[8 * r_idx +: 8];
                w_last = (r_idx == 3'd0) && !r_job.blk;
            end
            mbcf_pkg::S_BID: begin
                w_byte = mbcf_pkg::BLOCK_ID;
            end
            mbcf_pkg::S_BSIZE: begin
                w_byte = w_blen64[8 * r_idx +: 8];
                if (r_idx == 3'(r_bn - 4'd1)) begin
                    w_byte = w_byte | (mbcf_pkg::SIZE_MARKER >> r_idx);
                end
            end
            mbcf_pkg::S_TRACK: begin
                w_byte = r_job.audio ? mbcf_pkg::TRACK_AUDIO : mbcf_pkg::TRACK_VIDEO;
            end
            mbcf_pkg::S_RELH: begin
                w_byte = r_job.rel[15:8];
            end
            mbcf_pkg::S_RELL: begin
                w_byte = r_job.rel[7:0];
            end
            mbcf_pkg::S_FLAGS: begin
                w_byte = r_job.key ? mbcf_pkg::FLAG_KEY : mbcf_pkg::FLAG_NONE;
                w_last = 1'b1;
            end
            mbcf_pkg::S_REJ: begin
                w_kind = mbcf_pkg::KIND_REJECT;
                w_last = 1'b1;
            end
            default: begin
                w_byte = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_job <= i_job;
            r_csz <= w_csz;
            r_cn  <= mbcf_pkg::vint_len(w_csz);
            r_bn  <= mbcf_pkg::vint_len(64'(i_job.blen));
        end
        if (w_adv) begin
            r_kind  <= w_kind;
            r_byte  <= w_byte;
            r_chunk <= (w_kind == mbcf_pkg::KIND_CLUSTER) ? r_job.chunk : '0;
            r_last  <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mbcf_pkg::S_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.kind         = r_kind;
    assign o_result.data_byte    = r_byte;
    assign o_result.chunk_number = r_chunk;
    assign o_result.last         = r_last;
endmodule
